// ===== rtl/core/gbe_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gbe_pkg
// Shared types and constants for the glyph bitmap expander.
// ----------------------------------------------------------------------------
package gbe_pkg;

	localparam int COORD_BITS       = 10;
	localparam int WORD_BITS        = 16;
	localparam int COLOR_BITS       = 16;
	localparam int GWIDTH_BITS      = 7;
	localparam int FHEIGHT_BITS     = 7;
	localparam int CFG_INDEX_BITS   = 3;
	localparam int CFG_DATA_BITS    = 17;
	localparam int QUEUE_DEPTH      = 4;

	localparam int MAX_GLYPH_WIDTH_DEF  = 64;
	localparam int MAX_GLYPH_HEIGHT_DEF = 64;

	// Input item: bitmap_word, origin_x, origin_y, glyph_width from bit 0 up.
	localparam int IN_FIELD_BITS  = WORD_BITS + 2 * COORD_BITS + GWIDTH_BITS;
	localparam int IN_DATA_BITS   = ((IN_FIELD_BITS + 7) / 8) * 8;
	// Result item: pixel_x, pixel_y, pixel_color from bit 0 up.
	localparam int OUT_FIELD_BITS = 2 * COORD_BITS + COLOR_BITS;
	localparam int OUT_DATA_BITS  = ((OUT_FIELD_BITS + 7) / 8) * 8;

	// Leftmost pixel of a bitmap word.
	localparam logic [WORD_BITS-1:0] LEFT_PIXEL = 16'h8000;
	localparam int LAST_PIXEL_IDX = 15;

	// Configuration register indexes.
	localparam logic [CFG_INDEX_BITS-1:0] REG_FOREGROUND   = 3'd0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_BACKGROUND   = 3'd1;
	localparam logic [CFG_INDEX_BITS-1:0] REG_FONT_HEIGHT  = 3'd2;
	localparam logic [CFG_INDEX_BITS-1:0] REG_PANEL_WIDTH  = 3'd3;
	localparam logic [CFG_INDEX_BITS-1:0] REG_PANEL_HEIGHT = 3'd4;

	typedef struct packed {
		logic [COLOR_BITS-1:0]   foreground;
		logic [COLOR_BITS:0]     background;   // bit 16 set: transparent mode
		logic [FHEIGHT_BITS-1:0] font_height;
		logic [COORD_BITS-1:0]   panel_width;
		logic [COORD_BITS-1:0]   panel_height;
	} cfg_t;

	// One classified word, ready for pixel expansion.
	typedef struct packed {
		logic [WORD_BITS-1:0]  emit;      // pixels to emit, bit 15 leftmost
		logic [WORD_BITS-1:0]  bits;      // raw bitmap word
		logic [COORD_BITS-1:0] x0;        // column of bit 15
		logic [COORD_BITS-1:0] y;
		logic [COLOR_BITS-1:0] fg;
		logic [COLOR_BITS-1:0] bg;
		logic                  glyph_end;
	} job_t;

endpackage
`default_nettype wire

// ===== rtl/core/glyph_bitmap_expander_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// glyph_bitmap_expander_unit
// Color expansion of 1-bit glyph bitmap words into RGB565 panel pixels.
// ----------------------------------------------------------------------------
// Flow: an accepted word's job is written into the queue, loaded into the
//   back end, then its first pixel is registered on the output.
// Throughput: one pixel per cycle from the back end while the output is not
//   stalled; a word emits up to 16 pixels, and a word that emits nothing is
//   not queued. The 4-entry job queue takes words while the back end is busy.
// Reset: arst_n clears glyph tracking, queue and output valid at once and
//   loads the registers with white foreground, transparent mode, 16-row
//   font and a 320 x 240 panel.
// ----------------------------------------------------------------------------
module glyph_bitmap_expander_unit #(
	parameter int MAX_GLYPH_WIDTH  = gbe_pkg::MAX_GLYPH_WIDTH_DEF,
	parameter int MAX_GLYPH_HEIGHT = gbe_pkg::MAX_GLYPH_HEIGHT_DEF
) (
	input  wire                                  clk,
	input  wire                                  arst_n,
	// bitmap word input
	input  wire                                  s_tvalid,
	output logic                                 s_tready,
	// [15:0] bitmap_word, [25:16] origin_x, [35:26] origin_y, [42:36] glyph_width
	input  wire  [gbe_pkg::IN_DATA_BITS-1:0]     s_tdata,
	// [0] glyph_start
	input  wire                                  s_tuser,
	// pixel output
	output logic                                 m_tvalid,
	input  wire                                  m_tready,
	// [9:0] pixel_x, [19:10] pixel_y, [35:20] pixel_color
	output logic [gbe_pkg::OUT_DATA_BITS-1:0]    m_tdata,
	output logic                                 m_tlast,   // word_last
	// [0] glyph_last
	output logic                                 m_tuser,
	// configuration writes
	input  wire                                  cfg_we,
	input  wire  [gbe_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
	input  wire  [gbe_pkg::CFG_DATA_BITS-1:0]    cfg_data
);
	import gbe_pkg::*;

	localparam int OX_LSB = WORD_BITS;
	localparam int OY_LSB = OX_LSB + COORD_BITS;
	localparam int GW_LSB = OY_LSB + COORD_BITS;

	cfg_t                  cfg_q;
	logic                  in_fire, job_valid, q_full, q_valid, q_pop;
	job_t                  job, q_job;
	logic [COORD_BITS-1:0] pixel_x, pixel_y;
	logic [COLOR_BITS-1:0] pixel_color;

	// Register file: write-only, taken whenever the enable is high.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.foreground   <= 16'hFFFF;
			cfg_q.background   <= 17'h1FFFF;
			cfg_q.font_height  <= FHEIGHT_BITS'(16);
			cfg_q.panel_width  <= COORD_BITS'(320);
			cfg_q.panel_height <= COORD_BITS'(240);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_FOREGROUND:   cfg_q.foreground   <= cfg_data[COLOR_BITS-1:0];
				REG_BACKGROUND:   cfg_q.background   <= cfg_data[COLOR_BITS:0];
				REG_FONT_HEIGHT:  cfg_q.font_height  <= cfg_data[FHEIGHT_BITS-1:0];
				REG_PANEL_WIDTH:  cfg_q.panel_width  <= cfg_data[COORD_BITS-1:0];
				REG_PANEL_HEIGHT: cfg_q.panel_height <= cfg_data[COORD_BITS-1:0];
				default: ;
			endcase
		end
	end

	// Take a word whenever the queue has room for its job.
	assign s_tready = !q_full;
	assign in_fire  = s_tvalid && s_tready;

	gbe_front #(
		.MAX_GLYPH_WIDTH  (MAX_GLYPH_WIDTH),
		.MAX_GLYPH_HEIGHT (MAX_GLYPH_HEIGHT)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.in_fire     (in_fire),
		.bitmap_word (s_tdata[WORD_BITS-1:0]),
		.glyph_start (s_tuser),
		.origin_x    (s_tdata[OX_LSB +: COORD_BITS]),
		.origin_y    (s_tdata[OY_LSB +: COORD_BITS]),
		.glyph_width (s_tdata[GW_LSB +: GWIDTH_BITS]),
		.job_valid   (job_valid),
		.job         (job)
	);

	gbe_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (job_valid),
		.wr_job   (job),
		.full     (q_full),
		.rd_valid (q_valid),
		.rd_pop   (q_pop),
		.rd_job   (q_job)
	);

	gbe_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_valid     (q_valid),
		.q_job       (q_job),
		.q_pop       (q_pop),
		.out_valid   (m_tvalid),
		.out_ready   (m_tready),
		.pixel_x     (pixel_x),
		.pixel_y     (pixel_y),
		.pixel_color (pixel_color),
		.word_last   (m_tlast),
		.glyph_last  (m_tuser)
	);

	// Pack the pixel fields, zero fill up to whole bytes.
	assign m_tdata = OUT_DATA_BITS'({pixel_color, pixel_y, pixel_x});

endmodule
`default_nettype wire

// ===== rtl/core/gbe_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gbe_front
// Glyph tracking: clip check, row and column position, pixel mask per word.
// ----------------------------------------------------------------------------
module gbe_front #(
	parameter int MAX_GLYPH_WIDTH  = gbe_pkg::MAX_GLYPH_WIDTH_DEF,
	parameter int MAX_GLYPH_HEIGHT = gbe_pkg::MAX_GLYPH_HEIGHT_DEF
) (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  wire  gbe_pkg::cfg_t                 cfg,
	input  wire                                 in_fire,
	input  wire  [gbe_pkg::WORD_BITS-1:0]       bitmap_word,
	input  wire                                 glyph_start,
	input  wire  [gbe_pkg::COORD_BITS-1:0]      origin_x,
	input  wire  [gbe_pkg::COORD_BITS-1:0]      origin_y,
	input  wire  [gbe_pkg::GWIDTH_BITS-1:0]     glyph_width,
	output logic                                job_valid,
	output gbe_pkg::job_t                       job
);
	import gbe_pkg::*;

	localparam int WW = $clog2(MAX_GLYPH_WIDTH + 1);
	localparam int HW = $clog2(MAX_GLYPH_HEIGHT + 1);

	logic [WW-1:0]         col_q, width_q;
	logic [HW-1:0]         row_q;
	logic [COORD_BITS-1:0] base_x_q, base_y_q;
	logic                  active_q;

	logic [WW-1:0]         w_sat, col_c, width_c, rem;
	logic [HW-1:0]         h_eff, row_c;
	logic [COORD_BITS-1:0] bx_c, by_c;
	logic                  fits, active_c, row_end, glyph_end;
	logic [WORD_BITS-1:0]  seg_mask, emit;

	always_comb begin
		w_sat = (32'(glyph_width) > MAX_GLYPH_WIDTH) ? WW'(MAX_GLYPH_WIDTH) : WW'(glyph_width);
		h_eff = (32'(cfg.font_height) > MAX_GLYPH_HEIGHT) ? HW'(MAX_GLYPH_HEIGHT)
			: HW'(cfg.font_height);
		fits = (w_sat != '0) && (h_eff != '0)
			&& (({1'b0, origin_x} + (COORD_BITS+1)'(w_sat)) <= {1'b0, cfg.panel_width})
			&& (({1'b0, origin_y} + (COORD_BITS+1)'(h_eff)) <= {1'b0, cfg.panel_height});

		// A start word restarts the glyph, or drops it when it crosses the edge.
		if (glyph_start) begin
			active_c = fits;
			col_c    = '0;
			row_c    = '0;
			width_c  = w_sat;
			bx_c     = origin_x;
			by_c     = origin_y;
		end else begin
			active_c = active_q;
			col_c    = col_q;
			row_c    = row_q;
			width_c  = width_q;
			bx_c     = base_x_q;
			by_c     = base_y_q;
		end

		rem       = width_c - col_c;
		row_end   = (32'(rem) <= WORD_BITS);
		glyph_end = row_end && (({1'b0, row_c} + 1'b1) >= {1'b0, h_eff});

		for (int i = 0; i < WORD_BITS; i++) begin
			seg_mask[LAST_PIXEL_IDX-i] = (32'(rem) > i);
		end
		emit = cfg.background[COLOR_BITS] ? (seg_mask & bitmap_word) : seg_mask;

		job.emit      = emit;
		job.bits      = bitmap_word;
		job.x0        = bx_c + COORD_BITS'(col_c);
		job.y         = by_c + COORD_BITS'(row_c);
		job.fg        = cfg.foreground;
		job.bg        = cfg.background[COLOR_BITS-1:0];
		job.glyph_end = glyph_end;
		job_valid     = in_fire && active_c && (emit != '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			col_q    <= '0;
			row_q    <= '0;
			width_q  <= '0;
			base_x_q <= '0;
			base_y_q <= '0;
		end else if (in_fire) begin
			width_q  <= width_c;
			base_x_q <= bx_c;
			base_y_q <= by_c;
			if (!active_c) begin
				active_q <= 1'b0;
			end else if (row_end) begin
				col_q    <= '0;
				row_q    <= row_c + 1'b1;
				active_q <= !glyph_end;
			end else begin
				col_q    <= col_c + WW'(WORD_BITS);
				row_q    <= row_c;
				active_q <= 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

// ===== rtl/core/gbe_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gbe_queue
// Small job queue between the word front end and the pixel back end.
// ----------------------------------------------------------------------------
module gbe_queue (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 wr_en,
	input  wire  gbe_pkg::job_t wr_job,
	output logic                full,
	output logic                rd_valid,
	input  wire                 rd_pop,
	output gbe_pkg::job_t       rd_job
);
	import gbe_pkg::*;

	localparam int PW = $clog2(QUEUE_DEPTH);
	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	job_t          mem [QUEUE_DEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_wr, do_rd;

	assign full     = (count_q == CW'(QUEUE_DEPTH));
	assign rd_valid = (count_q != '0);
	assign rd_job   = mem[rd_ptr_q];
	assign do_wr    = wr_en && !full;
	assign do_rd    = rd_pop && rd_valid;

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem[wr_ptr_q] <= wr_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (do_rd) rd_ptr_q <= rd_ptr_q + 1'b1;
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

// ===== rtl/core/gbe_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gbe_back
// Pixel expansion: one pixel per cycle from the current job, unless stalled.
// ----------------------------------------------------------------------------
module gbe_back (
	input  wire                               clk,
	input  wire                               arst_n,
	input  wire                               q_valid,
	input  wire  gbe_pkg::job_t               q_job,
	output logic                              q_pop,
	output logic                              out_valid,
	input  wire                               out_ready,
	output logic [gbe_pkg::COORD_BITS-1:0]    pixel_x,
	output logic [gbe_pkg::COORD_BITS-1:0]    pixel_y,
	output logic [gbe_pkg::COLOR_BITS-1:0]    pixel_color,
	output logic                              word_last,
	output logic                              glyph_last
);
	import gbe_pkg::*;

	job_t                 job_q;
	logic                 job_valid_q;
	logic [3:0]           idx;
	logic [WORD_BITS-1:0] sel, mask_next;
	logic                 out_free, fire, last;

	always_comb begin
		idx = '0;
		for (int i = LAST_PIXEL_IDX; i >= 0; i--) begin
			if (job_q.emit[LAST_PIXEL_IDX-i]) idx = 4'(i);
		end
		sel       = LEFT_PIXEL >> idx;
		mask_next = job_q.emit & ~sel;
		last      = (mask_next == '0);
		out_free  = !out_valid || out_ready;
		fire      = job_valid_q && out_free;
		q_pop     = q_valid && (!job_valid_q || (fire && last));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			job_valid_q <= 1'b0;
			out_valid   <= 1'b0;
		end else begin
			if (q_pop) begin
				job_valid_q <= 1'b1;
			end else if (fire && last) begin
				job_valid_q <= 1'b0;
			end
			if (fire) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			job_q <= q_job;
		end else if (fire) begin
			job_q.emit <= mask_next;
		end
		if (fire) begin
			pixel_x     <= job_q.x0 + COORD_BITS'(idx);
			pixel_y     <= job_q.y;
			pixel_color <= ((job_q.bits & sel) != '0) ? job_q.fg : job_q.bg;
			word_last   <= last;
			glyph_last  <= job_q.glyph_end;
		end
	end

endmodule
`default_nettype wire
